### sv/stosc_pkg.sv
// Package for the swept tone oscillator: register indexes, default sizes and
// the elaboration-time functions that build the sine table contents.
// No dependencies.
`default_nettype none

package stosc_pkg;

  localparam int SineAddrBitsDefault = 10;
  localparam int PhaseBitsDefault    = 32;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 32;
  localparam int StepBits     = 32;
  localparam int SampleBits   = 16;

  localparam logic [CfgIndexBits-1:0] RegWaveShape  = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegSweepMode  = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegStartStep  = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegFinishStep = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegSweepDelta = 3'd4;

  localparam logic [1:0] ShapeSine   = 2'd0;
  localparam logic [1:0] ShapeSaw    = 2'd1;
  localparam logic [1:0] ShapeSquare = 2'd2;

  localparam logic [1:0] SweepConst    = 2'd0;
  localparam logic [1:0] SweepSawtooth = 2'd1;
  localparam logic [1:0] SweepTriangle = 2'd2;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1 << 30;

  // Magnitude of 32768*sin(pi/2 * k/q), q = 2**qbits, Q2.30 Horner series.
  function automatic logic [63:0] quarter_sine(logic [63:0] k, int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    x = (HalfPiQ30 * k) >> qbits;
    x2 = (x * x) >> 30;
    t = OneQ30;
    for (int n = 0; n < 5; n++) begin
      p = (x2 * t) >> 30;
      case (n)
        0: d = p / 110;
        1: d = p / 72;
        2: d = p / 42;
        3: d = p / 20;
        default: d = p / 6;
      endcase
      t = (d >= OneQ30) ? 64'd0 : OneQ30 - d;
    end
    s = (x * t) >> 30;
    return (s + 64'd16384) >> 15;
  endfunction

  // Full-period table entry i for a table of 2**addr_bits entries.
  function automatic logic [SampleBits-1:0] sine_entry(int i, int addr_bits);
    logic [63:0] half;
    logic [63:0] quarter;
    logic [63:0] j;
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] idx;
    logic [SampleBits-1:0] r;
    half = 64'd1 << (addr_bits - 1);
    quarter = 64'd1 << (addr_bits - 2);
    idx = 64'(i);
    j = idx & (half - 64'd1);
    k = (j <= quarter) ? j : half - j;
    m = quarter_sine(k, addr_bits - 2);
    if (idx < half) begin
      r = (m > 64'd32767) ? 16'h7fff : m[SampleBits-1:0];
    end else begin
      r = (m > 64'd32768) ? 16'h8000 : 16'((~m) + 64'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/swept_tone_oscillator.sv
// Swept tone oscillator top level: phase accumulator, sweep step update,
// sine table and output register. Depends on stosc_pkg.
//
// Usage:
//   Each transfer on the slave stream (s_axis_*) is one sample tick; bit 0 of
//   s_axis_tdata is the restart flag, which clears the phase and loads the
//   start step and sweep delta before the sample is formed. Each tick yields
//   one transfer on the master stream (m_axis_*) carrying a signed 16-bit
//   sample in m_axis_tdata.
//   The sample of a tick accepted at one edge is registered at that edge and
//   is valid after it. Throughput is one tick per cycle while the receiver does
//   not stall, set by the single phase add, table read and step update that sit
//   between the state registers and the output register.
//   Registers are written through cfg_we_i, cfg_index_i and cfg_wdata_i; the user
//   must write them only while the block is idle, which the block does not
//   enforce; indexes beyond the list are ignored. Reset clears the config registers,
//   phase, step, delta and output valid, not the output sample. The sine table is
//   a fixed ROM and needs no fill after reset. When the receiver stalls, the held
//   sample stays on m_axis_tdata and new ticks are taken only as it is taken.
`default_nettype none

module swept_tone_oscillator
  import stosc_pkg::*;
#(
  parameter int SINE_ADDR_BITS = SineAddrBitsDefault,
  parameter int PHASE_BITS     = PhaseBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output      logic                    s_axis_tready,
  input  wire logic [7:0]              s_axis_tdata,   // [0] restart, [7:1] zero
  output      logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output      logic [SampleBits-1:0]   m_axis_tdata,   // [15:0] sample
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_wdata_i
);

  localparam int RomDepth = 2 ** SINE_ADDR_BITS;

  typedef logic [SampleBits-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < RomDepth; i++) begin
      r[i] = sine_entry(i, SINE_ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [1:0]            wave_shape_q;
  logic [1:0]            sweep_mode_q;
  logic [StepBits-1:0]   start_step_q;
  logic [StepBits-1:0]   finish_step_q;
  logic [StepBits-1:0]   sweep_delta_q;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic [StepBits-1:0]   delta_q, delta_d;

  logic                  out_valid_q;
  logic                  use_rom_q;
  logic [SampleBits-1:0] rom_q;
  logic [SampleBits-1:0] alt_q, alt_d;

  logic                  accept;
  logic                  restart;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [StepBits-1:0]   step_cur;
  logic [StepBits-1:0]   delta_cur;
  logic [SampleBits-1:0] top16;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic [StepBits-1:0]   delta_neg;
  logic [StepBits-1:0]   delta_use;
  logic [StepBits+1:0]   step_sum;
  logic [StepBits-1:0]   step_sat;
  logic                  in_range;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = use_rom_q ? rom_q : alt_q;

  always_comb begin
    phase_cur = restart ? '0 : phase_q;
    step_cur  = restart ? start_step_q : step_q;
    delta_cur = restart ? sweep_delta_q : delta_q;

    top16    = phase_cur[PHASE_BITS-1 -: SampleBits];
    rom_addr = phase_cur[PHASE_BITS-1 -: SINE_ADDR_BITS];

    case (wave_shape_q)
      ShapeSaw:    alt_d = {~top16[SampleBits-1], top16[SampleBits-2:0]};
      ShapeSquare: alt_d = top16[SampleBits-1] ? 16'h7fff : 16'h8000;
      default:     alt_d = '0;
    endcase

    phase_d = phase_cur + PHASE_BITS'(step_cur);

    delta_neg = (delta_cur == 32'h8000_0000) ? 32'h7fff_ffff : (~delta_cur) + 32'd1;
    in_range  = (step_cur >= start_step_q) && (step_cur <= finish_step_q);

    delta_d   = delta_cur;
    delta_use = delta_cur;
    if (sweep_mode_q == SweepTriangle && !in_range) begin
      delta_d   = delta_neg;
      delta_use = delta_neg;
    end

    step_sum = {2'b00, step_cur} + {{2{delta_use[StepBits-1]}}, delta_use};
    if (step_sum[StepBits+1]) begin
      step_sat = '0;
    end else if (step_sum[StepBits]) begin
      step_sat = '1;
    end else begin
      step_sat = step_sum[StepBits-1:0];
    end

    case (sweep_mode_q)
      SweepSawtooth: step_d = (step_cur <= finish_step_q) ? step_sat : start_step_q;
      SweepTriangle: step_d = step_sat;
      default:       step_d = step_cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q  <= '0;
      sweep_mode_q  <= '0;
      start_step_q  <= '0;
      finish_step_q <= '0;
      sweep_delta_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWaveShape:  wave_shape_q  <= cfg_wdata_i[1:0];
        RegSweepMode:  sweep_mode_q  <= cfg_wdata_i[1:0];
        RegStartStep:  start_step_q  <= cfg_wdata_i;
        RegFinishStep: finish_step_q <= cfg_wdata_i;
        RegSweepDelta: sweep_delta_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      step_q      <= '0;
      delta_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        step_q  <= step_d;
        delta_q <= delta_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rom_q     <= SineRom[rom_addr];
      alt_q     <= alt_d;
      use_rom_q <= (wave_shape_q == ShapeSine);
    end
  end

endmodule

`default_nettype wire
